// ----- design/lzd_pkg.sv -----
`default_nettype none

package lzd_pkg;

   localparam int WINDOW_DEPTH = 65536;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int OUT_DEPTH = 3;
   localparam int OUT_PW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_END     = 2'd2,
      OP_RSVD    = 2'd3
   } lzd_op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_END    = 2'd1,
      ST_TRUNC  = 2'd2,
      ST_REJECT = 2'd3
   } lzd_status_type;

   typedef enum logic [2:0] {
      PH_LIT_LEN1   = 3'd0,
      PH_LIT_LEN2   = 3'd1,
      PH_LITERAL    = 3'd2,
      PH_MATCH_LEN1 = 3'd3,
      PH_MATCH_LEN2 = 3'd4,
      PH_OFF_LOW    = 3'd5,
      PH_OFF_HIGH   = 3'd6,
      PH_COPY       = 3'd7
   } lzd_phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFFSET_BITS   = 3'd0,
      REG_MAX_LIT_LEN   = 3'd1,
      REG_MAX_MATCH_LEN = 3'd2,
      REG_OFF_ON_ZERO   = 3'd3,
      REG_INVERT_OFF    = 3'd4,
      REG_ABS_BASE      = 3'd5
   } lzd_reg_type;

   // one accepted item as handed from the sequencer to the window stage
   typedef struct packed {
      logic              go;
      logic              is_copy;
      logic              wr_en;
      logic [WIN_AW-1:0] wr_idx;
      logic [WIN_AW-1:0] rd_idx;
      logic [7:0]        lit_byte;
      logic              copy_pending;
      logic [1:0]        status;
   } lzd_cmd_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       copy_pending;
      logic [1:0] status;
   } lzd_rsp_type;

endpackage

`default_nettype wire

// ----- design/lzd_channels.sv -----
`default_nettype none

interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface lzd_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       copy_pending;
   logic [1:0] status;

   modport source (output valid, output out_valid, output out_byte,
                   output copy_pending, output status, input ready);
   modport sink   (input valid, input out_valid, input out_byte,
                   input copy_pending, input status, output ready);
endinterface

`default_nettype wire

// ----- design/lz_literal_match_decoder_top.sv -----
`default_nettype none

// channel   dir  handshake     payload
// req_chan  in   valid/ready   opcode[1:0], data_byte[7:0]
// rsp_chan  out  valid/ready   out_valid, out_byte[7:0], copy_pending, status[1:0]
// csr_*     in   csr_wr_en     csr_index[2:0], csr_wdata[16:0]
//
// One item per cycle sustained while rsp_chan keeps up; results pass s1, then a slot.
// The window is a 64K x 8 array with a registered read; a byte written by the
// previous item is forwarded around the array. Three result slots absorb a stalled
// rsp side; req_chan.ready depends on registered state only. Synchronous reset puts
// the decoder at the first literal length byte; window contents are not cleared.

module lz_literal_match_decoder_top (
   input  logic                           clock,
   input  logic                           reset,
   lzd_req_if.sink                        req_chan,
   lzd_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [lzd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lzd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lzd_pkg::lzd_cmd_type       cmd;
   lzd_pkg::lzd_rsp_type       push_data;
   lzd_pkg::lzd_rsp_type       head_data;
   logic                       accept;
   logic                       s1_busy;
   logic                       push;
   logic                       pop;
   logic                       head_valid;
   logic [lzd_pkg::OUT_CW-1:0] count;

   // room for everything in flight plus one new item
   assign req_chan.ready = (lzd_pkg::OUT_CW'(count) + lzd_pkg::OUT_CW'(s1_busy))
                           < lzd_pkg::OUT_CW'(lzd_pkg::OUT_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = head_valid && rsp_chan.ready;

   lzd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (req_chan.opcode),
      .data_byte (req_chan.data_byte),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   lzd_window u_window (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .s1_busy   (s1_busy),
      .push      (push),
      .push_data (push_data)
   );

   lzd_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (count)
   );

   assign rsp_chan.valid        = head_valid;
   assign rsp_chan.out_valid    = head_data.out_valid;
   assign rsp_chan.out_byte     = head_data.out_byte;
   assign rsp_chan.copy_pending = head_data.copy_pending;
   assign rsp_chan.status       = head_data.status;

endmodule

`default_nettype wire

// ----- design/lzd_ctrl.sv -----
`default_nettype none

module lzd_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     opcode,
   input  logic [7:0]                     data_byte,
   input  logic                           csr_wr_en,
   input  logic [lzd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lzd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lzd_pkg::lzd_cmd_type           cmd
);

   // configuration
   logic [4:0]  off_bits_ff;
   logic [15:0] max_lit_ff;
   logic [15:0] max_match_ff;
   logic        off_on_zero_ff;
   logic        invert_ff;
   logic [16:0] abs_base_ff;

   // decode state
   lzd_pkg::lzd_phase_type phase_ff, phase_in;
   logic [15:0] run_ff, run_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  off_low_ff, off_low_in;
   logic [15:0] wpos_ff, wpos_in;
   logic [15:0] cptr_ff, cptr_in;
   logic        fin_ff, fin_in;

   logic [15:0] mask;
   logic [15:0] len_two;
   logic        lit_hit, match_hit, start;
   logic [15:0] lit_val, match_val, start_off, off_x;
   lzd_pkg::lzd_status_type status;
   logic        wr_en, is_copy;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_bits_ff    <= 5'd8;
         max_lit_ff     <= 16'd255;
         max_match_ff   <= 16'd255;
         off_on_zero_ff <= 1'b0;
         invert_ff      <= 1'b0;
         abs_base_ff    <= 17'h1FFFF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lzd_pkg::REG_OFFSET_BITS:   off_bits_ff    <= csr_wdata[4:0];
            lzd_pkg::REG_MAX_LIT_LEN:   max_lit_ff     <= csr_wdata[15:0];
            lzd_pkg::REG_MAX_MATCH_LEN: max_match_ff   <= csr_wdata[15:0];
            lzd_pkg::REG_OFF_ON_ZERO:   off_on_zero_ff <= csr_wdata[0];
            lzd_pkg::REG_INVERT_OFF:    invert_ff      <= csr_wdata[0];
            lzd_pkg::REG_ABS_BASE:      abs_base_ff    <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lzd_pkg::PH_LIT_LEN1;
         run_ff     <= '0;
         first_ff   <= '0;
         off_low_ff <= '0;
         wpos_ff    <= '0;
         cptr_ff    <= '0;
         fin_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         run_ff     <= run_in;
         first_ff   <= first_in;
         off_low_ff <= off_low_in;
         wpos_ff    <= wpos_in;
         cptr_ff    <= cptr_in;
         fin_ff     <= fin_in;
      end
   end

   assign mask    = (off_bits_ff > 5'd8) ? 16'hFFFF : 16'h00FF;
   assign len_two = {8'd0, first_ff} + {1'b0, data_byte, 7'd0};

   always_comb begin
      phase_in   = phase_ff;
      run_in     = run_ff;
      first_in   = first_ff;
      off_low_in = off_low_ff;
      wpos_in    = wpos_ff;
      cptr_in    = cptr_ff;
      fin_in     = fin_ff;
      status     = lzd_pkg::ST_OK;
      wr_en      = 1'b0;
      is_copy    = 1'b0;
      lit_hit    = 1'b0;
      lit_val    = {8'd0, data_byte};
      match_hit  = 1'b0;
      match_val  = {8'd0, data_byte};
      start      = 1'b0;
      start_off  = {8'd0, data_byte};
      off_x      = '0;

      if (accept) begin
         priority if (fin_ff || opcode == lzd_pkg::OP_RSVD) begin
            status = lzd_pkg::ST_REJECT;
         end else if (opcode == lzd_pkg::OP_END) begin
            if (phase_ff == lzd_pkg::PH_COPY) begin
               status = lzd_pkg::ST_REJECT;
            end else begin
               status = (phase_ff == lzd_pkg::PH_LIT_LEN1 ||
                         phase_ff == lzd_pkg::PH_MATCH_LEN1) ?
                        lzd_pkg::ST_END : lzd_pkg::ST_TRUNC;
               fin_in = 1'b1;
            end
         end else if (opcode == lzd_pkg::OP_ADVANCE) begin
            if (phase_ff != lzd_pkg::PH_COPY) begin
               status = lzd_pkg::ST_REJECT;
            end else begin
               wr_en   = 1'b1;
               is_copy = 1'b1;
               wpos_in = wpos_ff + 16'd1;
               cptr_in = (cptr_ff + 16'd1) & mask;
               run_in  = run_ff - 16'd1;
               if (run_in == 16'd0)
                  phase_in = lzd_pkg::PH_LIT_LEN1;
            end
         end else begin
            unique case (phase_ff)
               lzd_pkg::PH_LIT_LEN1: begin
                  if (max_lit_ff > 16'd255 && data_byte[7]) begin
                     first_in = data_byte;
                     phase_in = lzd_pkg::PH_LIT_LEN2;
                  end else begin
                     lit_hit = 1'b1;
                  end
               end
               lzd_pkg::PH_LIT_LEN2: begin
                  lit_hit = 1'b1;
                  lit_val = len_two;
               end
               lzd_pkg::PH_LITERAL: begin
                  wr_en   = 1'b1;
                  wpos_in = wpos_ff + 16'd1;
                  run_in  = run_ff - 16'd1;
                  if (run_in == 16'd0)
                     phase_in = lzd_pkg::PH_MATCH_LEN1;
               end
               lzd_pkg::PH_MATCH_LEN1: begin
                  if (max_match_ff > 16'd255 && data_byte[7]) begin
                     first_in = data_byte;
                     phase_in = lzd_pkg::PH_MATCH_LEN2;
                  end else begin
                     match_hit = 1'b1;
                  end
               end
               lzd_pkg::PH_MATCH_LEN2: begin
                  match_hit = 1'b1;
                  match_val = len_two;
               end
               lzd_pkg::PH_OFF_LOW: begin
                  if (off_bits_ff > 5'd8) begin
                     off_low_in = data_byte;
                     phase_in   = lzd_pkg::PH_OFF_HIGH;
                  end else begin
                     start = 1'b1;
                  end
               end
               lzd_pkg::PH_OFF_HIGH: begin
                  start     = 1'b1;
                  start_off = {data_byte, off_low_ff};
               end
               lzd_pkg::PH_COPY: begin
                  status = lzd_pkg::ST_REJECT;
               end
               default: status = lzd_pkg::ST_REJECT;
            endcase
         end

         if (lit_hit) begin
            run_in   = lit_val;
            phase_in = (lit_val != 16'd0) ? lzd_pkg::PH_LITERAL : lzd_pkg::PH_MATCH_LEN1;
         end

         if (match_hit) begin
            run_in = match_val;
            if (match_val == 16'd0 && !off_on_zero_ff) begin
               phase_in = lzd_pkg::PH_LIT_LEN1;
            end else if (off_bits_ff != 5'd0) begin
               phase_in = lzd_pkg::PH_OFF_LOW;
            end else begin
               start     = 1'b1;
               start_off = '0;
            end
         end

         if (start) begin
            off_x = invert_ff ? (start_off ^ mask) : start_off;
            // relative: offset 0 points at the byte just written
            if (abs_base_ff[16])
               cptr_in = (wpos_ff - off_x - 16'd1) & mask;
            else
               cptr_in = (off_x - abs_base_ff[15:0]) & mask;
            phase_in = (run_in != 16'd0) ? lzd_pkg::PH_COPY : lzd_pkg::PH_LIT_LEN1;
         end
      end
   end

   always_comb begin
      cmd.go           = accept;
      cmd.is_copy      = is_copy;
      cmd.wr_en        = wr_en;
      cmd.wr_idx       = wpos_ff & mask;
      cmd.rd_idx       = cptr_ff & mask;
      cmd.lit_byte     = data_byte;
      cmd.copy_pending = (phase_in == lzd_pkg::PH_COPY) && (status == lzd_pkg::ST_OK);
      cmd.status       = status;
   end

endmodule

`default_nettype wire

// ----- design/lzd_window.sv -----
`default_nettype none

module lzd_window (
   input  logic                 clock,
   input  logic                 reset,
   input  lzd_pkg::lzd_cmd_type cmd,
   output logic                 s1_busy,
   output logic                 push,
   output lzd_pkg::lzd_rsp_type push_data
);

   logic [7:0] win_mem [lzd_pkg::WINDOW_DEPTH];

   logic                        s1_valid_ff;
   logic                        s1_copy_ff;
   logic                        s1_wr_ff;
   logic [lzd_pkg::WIN_AW-1:0]  s1_widx_ff;
   logic [7:0]                  s1_lit_ff;
   logic                        s1_pend_ff;
   logic [1:0]                  s1_status_ff;
   logic [7:0]                  rd_ff;
   logic                        fwd_hit_ff;
   logic [7:0]                  fwd_byte_ff;
   logic [7:0]                  s1_byte;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= cmd.go;
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         s1_copy_ff   <= cmd.is_copy;
         s1_wr_ff     <= cmd.wr_en;
         s1_widx_ff   <= cmd.wr_idx;
         s1_lit_ff    <= cmd.lit_byte;
         s1_pend_ff   <= cmd.copy_pending;
         s1_status_ff <= cmd.status;
         // the item in s1 writes at this same edge; the array read sees old data
         fwd_hit_ff   <= s1_valid_ff && s1_wr_ff && (s1_widx_ff == cmd.rd_idx);
         fwd_byte_ff  <= s1_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_wr_ff)
         win_mem[s1_widx_ff] <= s1_byte;
      rd_ff <= win_mem[cmd.rd_idx];
   end

   assign s1_byte = !s1_copy_ff ? s1_lit_ff : (fwd_hit_ff ? fwd_byte_ff : rd_ff);

   assign s1_busy                = s1_valid_ff;
   assign push                   = s1_valid_ff;
   assign push_data.out_valid    = s1_wr_ff;
   assign push_data.out_byte     = s1_wr_ff ? s1_byte : 8'd0;
   assign push_data.copy_pending = s1_pend_ff;
   assign push_data.status       = s1_status_ff;

endmodule

`default_nettype wire

// ----- design/lzd_out_fifo.sv -----
`default_nettype none

module lzd_out_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lzd_pkg::lzd_rsp_type        push_data,
   input  logic                        pop,
   output logic                        head_valid,
   output lzd_pkg::lzd_rsp_type        head_data,
   output logic [lzd_pkg::OUT_CW-1:0]  count
);

   lzd_pkg::lzd_rsp_type slot_ff [lzd_pkg::OUT_DEPTH];

   logic [lzd_pkg::OUT_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lzd_pkg::OUT_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lzd_pkg::OUT_CW-1:0] count_ff, count_in;

   function automatic logic [lzd_pkg::OUT_PW-1:0] ptr_next(
      input logic [lzd_pkg::OUT_PW-1:0] p
   );
      return (p == lzd_pkg::OUT_PW'(lzd_pkg::OUT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + lzd_pkg::OUT_CW'(push) - lzd_pkg::OUT_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

// ----- test/lz_literal_match_decoder_top_test.sv -----
`timescale 1ns / 1ps

module lz_literal_match_decoder_top_test;
   import lzd_pkg::*;

   typedef struct packed {
      logic [4:0]  ob;
      logic [15:0] max_lit;
      logic [15:0] max_match;
      logic        oz;
      logic        inv;
      logic [16:0] base;
   } dec_cfg_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lzd_req_if req_chan ();
   lzd_rsp_if rsp_chan ();

   lz_literal_match_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder copy: configuration
   logic [4:0]  cfg_ob        = 5'd8;
   logic [15:0] cfg_max_lit   = 16'd255;
   logic [15:0] cfg_max_match = 16'd255;
   logic        cfg_off_zero  = 1'b0;
   logic        cfg_invert    = 1'b0;
   logic [16:0] cfg_base      = 17'h1FFFF;

   // decoder copy: stream state and window
   lzd_phase_type dec_phase     = PH_LIT_LEN1;
   logic [15:0]   dec_run       = '0;
   logic [7:0]    dec_first_len = '0;
   logic [7:0]    dec_off_low   = '0;
   logic [15:0]   dec_wpos      = '0;
   logic [15:0]   dec_cptr      = '0;
   logic          dec_done      = 1'b0;
   logic [7:0]    win_mem     [WINDOW_DEPTH];
   bit            win_written [WINDOW_DEPTH];

   lzd_rsp_type decoded_q [$];
   lzd_rsp_type want_rsp;
   logic [15:0] planned_off;

   int src_gap_max    = 8;
   int sink_stall_max = 8;
   int sink_wait      = 0;
   int n_errors       = 0;
   int n_items        = 0;
   int n_rejected     = 0;
   int n_literal      = 0;
   int n_copied       = 0;
   int n_checked      = 0;
   int n_settings     = 1;
   int end_phase      = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int unsigned win_mask();
      return (cfg_ob > 5'd8) ? 32'hFFFF : 32'hFF;
   endfunction

   function automatic int win_idx(logic [15:0] a);
      return (a & win_mask()) % WINDOW_DEPTH;
   endfunction

   function automatic void put_byte(logic [7:0] x);
      win_mem[win_idx(dec_wpos)]     = x;
      win_written[win_idx(dec_wpos)] = 1'b1;
      dec_wpos                       = dec_wpos + 16'd1;
   endfunction

   function automatic logic [15:0] calc_copy_ptr(logic [15:0] off);
      int unsigned m, o;
      m = win_mask();
      o = off;
      if (cfg_invert) o = o ^ m;
      if (cfg_base[16]) return 16'((dec_wpos - o + m) & m);
      return 16'((o + m + 1 - cfg_base) & m);
   endfunction

   function automatic void begin_copy(logic [15:0] off);
      dec_cptr  = calc_copy_ptr(off);
      dec_phase = (dec_run != 0) ? PH_COPY : PH_LIT_LEN1;
   endfunction

   function automatic void lit_len_known(logic [15:0] n);
      dec_run   = n;
      dec_phase = (n != 0) ? PH_LITERAL : PH_MATCH_LEN1;
   endfunction

   function automatic void match_len_known(logic [15:0] n);
      dec_run = n;
      if (n == 0 && !cfg_off_zero) dec_phase = PH_LIT_LEN1;
      else if (cfg_ob != 0) dec_phase = PH_OFF_LOW;
      else begin_copy(16'd0);
   endfunction

   // expected decoder output for one accepted item; advances the decoder copy
   function automatic lzd_rsp_type decode_step(lzd_op_type op, logic [7:0] b);
      lzd_rsp_type r;
      logic [7:0]  x;
      r = '0;
      r.status = ST_OK;
      if (dec_done || op == OP_RSVD) begin
         r.status = ST_REJECT;
      end else if (op == OP_END) begin
         if (dec_phase == PH_COPY) begin
            r.status = ST_REJECT;
         end else begin
            r.status = (dec_phase == PH_LIT_LEN1 || dec_phase == PH_MATCH_LEN1) ?
                       ST_END : ST_TRUNC;
            dec_done = 1'b1;
         end
      end else if (op == OP_ADVANCE) begin
         if (dec_phase != PH_COPY) begin
            r.status = ST_REJECT;
         end else begin
            x = win_mem[win_idx(dec_cptr)];
            put_byte(x);
            dec_cptr    = 16'((dec_cptr + 1) & win_mask());
            r.out_valid = 1'b1;
            r.out_byte  = x;
            dec_run     = dec_run - 16'd1;
            if (dec_run == 0) dec_phase = PH_LIT_LEN1;
         end
      end else begin
         case (dec_phase)
            PH_LIT_LEN1: begin
               if (cfg_max_lit > 16'd255 && b >= 8'd128) begin
                  dec_first_len = b;
                  dec_phase     = PH_LIT_LEN2;
               end else begin
                  lit_len_known(16'(b));
               end
            end
            PH_LIT_LEN2: lit_len_known(16'(dec_first_len) + (16'(b) << 7));
            PH_LITERAL: begin
               put_byte(b);
               r.out_valid = 1'b1;
               r.out_byte  = b;
               dec_run     = dec_run - 16'd1;
               if (dec_run == 0) dec_phase = PH_MATCH_LEN1;
            end
            PH_MATCH_LEN1: begin
               if (cfg_max_match > 16'd255 && b >= 8'd128) begin
                  dec_first_len = b;
                  dec_phase     = PH_MATCH_LEN2;
               end else begin
                  match_len_known(16'(b));
               end
            end
            PH_MATCH_LEN2: match_len_known(16'(dec_first_len) + (16'(b) << 7));
            PH_OFF_LOW: begin
               if (cfg_ob > 5'd8) begin
                  dec_off_low = b;
                  dec_phase   = PH_OFF_HIGH;
               end else begin
                  begin_copy(16'(b));
               end
            end
            PH_OFF_HIGH: begin_copy({b, dec_off_low});
            default: r.status = ST_REJECT;
         endcase
      end
      r.copy_pending = !dec_done && dec_phase == PH_COPY && r.status != ST_REJECT;
      return r;
   endfunction

   // how far back from the write position the window holds written bytes
   function automatic int history_len();
      int unsigned m;
      int          d;
      m = win_mask();
      d = 0;
      while (d < m + 1 && d < 4096 && win_written[win_idx(16'(dec_wpos - d - 1))]) d++;
      return d;
   endfunction

   function automatic logic [7:0] len_byte(bit two_byte);
      int r;
      r = $urandom_range(0, 99);
      if (two_byte && r < 8) return 8'($urandom_range(128, 255));
      if (r < 80) return 8'($urandom_range(0, 6));
      if (r < 95) return 8'($urandom_range(7, 40));
      return 8'($urandom_range(41, two_byte ? 127 : 255));
   endfunction

   // well-formed next item for the current phase; matches only reach written bytes
   function automatic void next_item(input bit calm, output lzd_op_type op,
                                     output logic [7:0] b);
      int unsigned m, cp, offp;
      int          h, span, r;
      bit          can_copy;
      m  = win_mask();
      op = OP_BYTE;
      b  = 8'($urandom);
      r  = $urandom_range(0, 99);
      case (dec_phase)
         PH_COPY: op = OP_ADVANCE;
         PH_LIT_LEN1: b = calm ? 8'd0 : len_byte(cfg_max_lit > 16'd255);
         PH_LIT_LEN2, PH_MATCH_LEN2: begin
            if (calm || r < 70) b = 8'd0;
            else if (r < 95) b = 8'd1;
            else b = 8'($urandom_range(2, 3));
         end
         PH_LITERAL: if (r < 10) b = (r < 5) ? 8'hFF : 8'h00;
         PH_MATCH_LEN1: begin
            if (cfg_ob == 0) begin
               // no offset bytes: the source is fixed by the registers
               cp   = calc_copy_ptr(16'd0);
               span = (dec_wpos - cp) & m;
               if (span == 0) span = m + 1;
               can_copy = span <= history_len();
            end else begin
               can_copy = history_len() > 0;
            end
            b = (calm || !can_copy) ? 8'd0 : len_byte(cfg_max_match > 16'd255);
         end
         PH_OFF_LOW: begin
            if (dec_run != 0) begin
               h = history_len();
               if (r < 10) span = h;
               else span = $urandom_range(1, (h < 40) ? h : 40);
               cp = (dec_wpos - span) & m;
               if (cfg_base[16]) offp = (dec_wpos - 1 - cp) & m;
               else offp = (cp + cfg_base) & m;
               if (cfg_invert) offp = offp ^ m;
               planned_off = 16'(offp);
            end else begin
               planned_off = 16'($urandom);
            end
            b = planned_off[7:0];
         end
         PH_OFF_HIGH: b = planned_off[15:8];
         default: ;
      endcase
   endfunction

   task automatic send_item(lzd_op_type op, logic [7:0] b);
      int          gap;
      lzd_rsp_type r;
      gap = $urandom_range(0, src_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opcode    <= op;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      r = decode_step(op, b);
      decoded_q.push_back(r);
      n_items++;
      if (r.status == ST_REJECT) n_rejected++;
      if (r.out_valid && op == OP_BYTE) n_literal++;
      if (r.out_valid && op == OP_ADVANCE) n_copied++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(lzd_reg_type idx, int unsigned v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_OFFSET_BITS:   cfg_ob        = v[4:0];
         REG_MAX_LIT_LEN:   cfg_max_lit   = v[15:0];
         REG_MAX_MATCH_LEN: cfg_max_match = v[15:0];
         REG_OFF_ON_ZERO:   cfg_off_zero  = v[0];
         REG_INVERT_OFF:    cfg_invert    = v[0];
         REG_ABS_BASE:      cfg_base      = v[16:0];
         default: ;
      endcase
   endtask

   // finish the current run and match, drain, then reprogram every register
   task automatic apply_config(dec_cfg_type c);
      lzd_op_type op;
      logic [7:0] b;
      while (dec_phase != PH_LIT_LEN1) begin
         next_item(1'b1, op, b);
         send_item(op, b);
      end
      wait_idle();
      write_reg(REG_OFFSET_BITS, c.ob);
      write_reg(REG_MAX_LIT_LEN, c.max_lit);
      write_reg(REG_MAX_MATCH_LEN, c.max_match);
      write_reg(REG_OFF_ON_ZERO, c.oz);
      write_reg(REG_INVERT_OFF, c.inv);
      write_reg(REG_ABS_BASE, c.base);
   endtask

   function automatic dec_cfg_type cfg_setting(int k);
      dec_cfg_type c;
      case (k)
         0:  c = '{5'd8,  16'd255,   16'd255,   1'b0, 1'b0, 17'h1FFFF};
         1:  c = '{5'd0,  16'd1,     16'd1,     1'b1, 1'b0, 17'h1FFFF};
         2:  c = '{5'd1,  16'd256,   16'd256,   1'b0, 1'b1, 17'h00000};
         3:  c = '{5'd16, 16'd32895, 16'd32895, 1'b1, 1'b1, 17'h1FFFF};
         4:  c = '{5'd9,  16'd255,   16'd300,   1'b0, 1'b0, 17'h0FFFF};
         5:  c = '{5'd31, 16'hFFFF,  16'd1,     1'b1, 1'b0, 17'h10000};
         6:  c = '{5'd0,  16'd300,   16'd255,   1'b0, 1'b1, 17'h00005};
         7:  c = '{5'd12, 16'd1000,  16'd4000,  1'b0, 1'b1, 17'h08000};
         10: c = '{5'd4,  16'd0,     16'd255,   1'b1, 1'b0, 17'h1FFFF};
         default: begin
            c.ob        = 5'($urandom);
            c.max_lit   = 16'($urandom);
            c.max_match = 16'($urandom);
            c.oz        = 1'($urandom);
            c.inv       = 1'($urandom);
            c.base      = 17'($urandom);
         end
      endcase
      return c;
   endfunction

   task automatic run_random_stream(int target);
      int         good, iter;
      lzd_op_type op;
      logic [7:0] b;
      good = 0;
      iter = 0;
      while (good < target) begin
         if (iter % 64 == 0) begin
            src_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 8;
            sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
         end
         iter++;
         if ($urandom_range(0, 199) == 0) wait_idle();
         b = 8'($urandom);
         if ($urandom_range(0, 15) == 0) begin
            // noise the decoder has to turn away
            if ($urandom_range(0, 1) == 0) op = OP_RSVD;
            else op = (dec_phase == PH_COPY) ? OP_BYTE : OP_ADVANCE;
         end else begin
            next_item(1'b0, op, b);
            good++;
         end
         send_item(op, b);
      end
   endtask

   task automatic test_directed();
      src_gap_max    = 8;
      sink_stall_max = 8;
      send_item(OP_RSVD, 8'hFF);
      send_item(OP_ADVANCE, 8'h00);     // no copy pending
      send_item(OP_BYTE, 8'd3);         // three literals
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'h5A);
      send_item(OP_BYTE, 8'd0);         // empty match, no offset read
      send_item(OP_BYTE, 8'd0);         // empty literal run
      send_item(OP_BYTE, 8'd5);         // match of 5, overlapping its source
      send_item(OP_BYTE, 8'd2);
      send_item(OP_BYTE, 8'h77);        // stream byte during copy
      send_item(OP_END, 8'h00);         // end during copy
      repeat (5) send_item(OP_ADVANCE, 8'h00);
      send_item(OP_BYTE, 8'd1);
      send_item(OP_BYTE, 8'h80);
      send_item(OP_BYTE, 8'd1);
      send_item(OP_BYTE, 8'd0);         // previous byte
      send_item(OP_ADVANCE, 8'hFF);
      send_item(OP_RSVD, 8'h00);
      wait_idle();
   endtask

   task automatic test_register_settings();
      for (int k = 0; k <= 10; k++) begin
         apply_config(cfg_setting(k));
         n_settings++;
         run_random_stream(150);
      end
   endtask

   task automatic test_end_of_input();
      dec_cfg_type c;
      int          k;
      c = '{5'd16, 16'd300, 16'd300, 1'b1, 1'($urandom), 17'h1FFFF};
      apply_config(c);
      n_settings++;
      src_gap_max    = 8;
      sink_stall_max = 8;
      k = $urandom_range(0, 6);
      case (k)
         0: ;
         1: send_item(OP_BYTE, 8'h80);  // lost second length byte
         2: begin
            send_item(OP_BYTE, 8'd2);
            send_item(OP_BYTE, 8'h3C);
         end
         3: send_item(OP_BYTE, 8'd0);
         4: begin
            send_item(OP_BYTE, 8'd0);
            send_item(OP_BYTE, 8'h85);
         end
         5: begin
            send_item(OP_BYTE, 8'd0);
            send_item(OP_BYTE, 8'd0);
         end
         default: begin
            send_item(OP_BYTE, 8'd0);
            send_item(OP_BYTE, 8'd0);
            send_item(OP_BYTE, 8'($urandom));
         end
      endcase
      end_phase = dec_phase;
      send_item(OP_END, 8'($urandom));
      // everything after the end is turned away
      send_item(OP_BYTE, 8'($urandom));
      send_item(OP_ADVANCE, 8'($urandom));
      send_item(OP_RSVD, 8'($urandom));
      send_item(OP_END, 8'($urandom));
   endtask

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (decoded_q.size() == 0) begin
               n_errors++;
               $display("%0t: result with nothing expected, status %0h byte %0h",
                        $time, rsp_chan.status, rsp_chan.out_byte);
            end else begin
               want_rsp = decoded_q.pop_front();
               n_checked++;
               check_field("out_valid", want_rsp.out_valid, rsp_chan.out_valid);
               check_field("out_byte", want_rsp.out_byte, rsp_chan.out_byte);
               check_field("copy_pending", want_rsp.copy_pending, rsp_chan.copy_pending);
               check_field("status", want_rsp.status, rsp_chan.status);
            end
            sink_wait = $urandom_range(0, sink_stall_max);
         end
         if (sink_wait > 0) begin
            rsp_chan.ready <= 1'b0;
            sink_wait--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.opcode    = '0;
      req_chan.data_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_settings();
      test_end_of_input();

      wait_idle();
      repeat (8) @(posedge clock);
      $display("sent %0d items (%0d turned away) over %0d register settings, %0d results checked",
               n_items, n_rejected, n_settings, n_checked);
      $display("decoded %0d literal and %0d copied bytes, input ended in phase %0d",
               n_literal, n_copied, end_phase);
      if (n_errors == 0 && decoded_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- lz_literal_match_decoder_top.f -----
design/lzd_pkg.sv
design/lzd_channels.sv
design/lzd_ctrl.sv
design/lzd_window.sv
design/lzd_out_fifo.sv
design/lz_literal_match_decoder_top.sv
test/lz_literal_match_decoder_top_test.sv
